// ----- rtl/bpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and constants of the 24-bit bitmap stream parser
// Header layout offsets, the front-to-back command word, the result word.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int HDR_W        = 6;
  localparam int DIM_OFFSET   = 18;
  localparam int PIXEL_OFFSET = 54;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // header byte offsets
  localparam logic [HDR_W-1:0] WID_FIRST_OFS = HDR_W'(DIM_OFFSET);
  localparam logic [HDR_W-1:0] HGT_FIRST_OFS = HDR_W'(DIM_OFFSET + 4);
  localparam logic [HDR_W-1:0] HGT_END_OFS   = HDR_W'(DIM_OFFSET + 8);
  localparam logic [HDR_W-1:0] CHECK_OFS     = HDR_W'(DIM_OFFSET + 7);
  localparam logic [HDR_W-1:0] LAST_HDR_OFS  = HDR_W'(PIXEL_OFFSET - 1);

  typedef enum logic [1:0] {
    FPH_HEADER,
    FPH_STREAM,
    FPH_DONE
  } front_phase_t;

  typedef enum logic [1:0] {
    BPH_IDLE,
    BPH_PIXELS,
    BPH_PAD
  } back_phase_t;

  typedef enum logic {
    CMD_PIX,
    CMD_ERR
  } cmd_t;

  // control part of a command word
  typedef struct packed {
    cmd_t cmd;
    logic new_img;   // first pixel-area byte of a new image
  } mid_ctl_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;
    logic        size_error;
  } result_t;

endpackage

// ----- rtl/bpp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_fifo: small register queue
// QDEPTH entries of W bits; no write while full, no read while empty.
// ----------------------------------------------------------------------------
module bpp_fifo
  import bpp_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/bpp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_front: header parser
// Tracks the byte offset, assembles width and height, checks them and
// forwards pixel-area bytes (or one error command) to the back end.
// ----------------------------------------------------------------------------
module bpp_front
  import bpp_pkg::*;
#(
  parameter int MAX_DIM = 4096,
  parameter int DIM_W   = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [7:0]       data_byte,
  input  logic             file_start,
  input  logic             mid_full,
  output logic             mid_push,
  output mid_ctl_t         mid_ctl,
  output logic [7:0]       mid_data,
  output logic [DIM_W-1:0] mid_width,
  output logic [DIM_W-1:0] mid_height
);

  front_phase_t     phase_r, phase_nxt;
  logic [HDR_W-1:0] header_offset_r, header_offset_nxt;
  logic [31:0]      width_shift_r, width_shift_nxt;
  logic [31:0]      height_shift_r, height_shift_nxt;
  logic             first_r, first_nxt;

  always_comb begin
    front_phase_t     ph;
    logic [HDR_W-1:0] off;
    logic [31:0]      wsh;
    logic [31:0]      hsh;
    logic             bad;

    phase_nxt         = phase_r;
    header_offset_nxt = header_offset_r;
    width_shift_nxt   = width_shift_r;
    height_shift_nxt  = height_shift_r;
    first_nxt         = first_r;
    mid_push          = 1'b0;
    mid_ctl.cmd       = CMD_PIX;
    mid_ctl.new_img   = first_r;
    mid_data          = data_byte;
    mid_width         = width_shift_r[DIM_W-1:0];
    mid_height        = height_shift_r[DIM_W-1:0];

    // a start flag restarts parsing at offset 0
    ph  = file_start ? FPH_HEADER : phase_r;
    off = file_start ? '0 : header_offset_r;
    wsh = file_start ? '0 : width_shift_r;
    hsh = file_start ? '0 : height_shift_r;
    bad = 1'b0;

    if (push && !mid_full) begin
      case (ph)
        FPH_HEADER: begin
          if (off >= WID_FIRST_OFS && off < HGT_FIRST_OFS) begin
            wsh = {data_byte, wsh[31:8]};
          end else if (off >= HGT_FIRST_OFS && off < HGT_END_OFS) begin
            hsh = {data_byte, hsh[31:8]};
          end
          bad = (wsh == '0) || (wsh > 32'(MAX_DIM)) ||
                (hsh == '0) || (hsh > 32'(MAX_DIM));
          width_shift_nxt  = wsh;
          height_shift_nxt = hsh;
          phase_nxt        = FPH_HEADER;
          if (off == CHECK_OFS && bad) begin
            mid_push          = 1'b1;
            mid_ctl.cmd       = CMD_ERR;
            phase_nxt         = FPH_DONE;
            header_offset_nxt = off;
          end else if (off == LAST_HDR_OFS) begin
            phase_nxt         = FPH_STREAM;
            header_offset_nxt = '0;
            first_nxt         = 1'b1;
          end else begin
            header_offset_nxt = off + 1'b1;
          end
        end
        FPH_STREAM: begin
          mid_push  = 1'b1;
          first_nxt = 1'b0;
        end
        default: begin
          phase_nxt = FPH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= FPH_HEADER;
      header_offset_r <= '0;
      width_shift_r   <= '0;
      height_shift_r  <= '0;
      first_r         <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      header_offset_r <= header_offset_nxt;
      width_shift_r   <= width_shift_nxt;
      height_shift_r  <= height_shift_nxt;
      first_r         <= first_nxt;
    end
  end

endmodule

// ----- rtl/bpp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_back: pixel assembler
// Groups pixel-area bytes into BGR triples, counts columns and rows, skips
// row padding and builds the result words.
// ----------------------------------------------------------------------------
module bpp_back
  import bpp_pkg::*;
#(
  parameter int DIM_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             mid_empty,
  output logic             mid_pop,
  input  mid_ctl_t         mid_ctl,
  input  logic [7:0]       mid_data,
  input  logic [DIM_W-1:0] mid_width,
  input  logic [DIM_W-1:0] mid_height,
  input  logic             out_full,
  output logic             out_push,
  output result_t          out_word
);

  back_phase_t      bph_r, bph_nxt;
  logic [DIM_W-1:0] column_r, column_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       byte_in_pixel_r, byte_in_pixel_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [7:0]       held_blue_r, held_blue_nxt;
  logic [7:0]       held_green_r, held_green_nxt;

  always_comb begin
    back_phase_t      ph;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] rw;
    logic [1:0]       bip;
    logic             row_end;
    logic             last;

    bph_nxt           = bph_r;
    column_nxt        = column_r;
    row_nxt           = row_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    pad_nxt           = pad_r;
    held_blue_nxt     = held_blue_r;
    held_green_nxt    = held_green_r;
    out_push          = 1'b0;
    out_word          = '0;
    mid_pop           = !mid_empty && !out_full;

    ph  = mid_ctl.new_img ? BPH_PIXELS : bph_r;
    col = mid_ctl.new_img ? '0 : column_r;
    rw  = mid_ctl.new_img ? '0 : row_r;
    bip = mid_ctl.new_img ? '0 : byte_in_pixel_r;
    row_end = ((DIM_W + 1)'(col) + 1'b1) >= (DIM_W + 1)'(mid_width);
    last    = row_end && (((DIM_W + 1)'(rw) + 1'b1) >= (DIM_W + 1)'(mid_height));

    if (mid_pop) begin
      if (mid_ctl.cmd == CMD_ERR) begin
        out_push            = 1'b1;
        out_word.size_error = 1'b1;
        bph_nxt             = BPH_IDLE;
      end else begin
        bph_nxt           = ph;
        column_nxt        = col;
        row_nxt           = rw;
        byte_in_pixel_nxt = bip;
        case (ph)
          BPH_PAD: begin
            if (pad_r != 2'd0) begin
              pad_nxt = pad_r - 1'b1;
            end
            if (pad_r <= 2'd1) begin
              bph_nxt = BPH_PIXELS;
            end
          end
          BPH_PIXELS: begin
            if (bip == 2'd0) begin
              held_blue_nxt     = mid_data;
              byte_in_pixel_nxt = 2'd1;
            end else if (bip == 2'd1) begin
              held_green_nxt    = mid_data;
              byte_in_pixel_nxt = 2'd2;
            end else begin
              out_push              = 1'b1;
              out_word.blue         = held_blue_r;
              out_word.green        = held_green_r;
              out_word.red          = mid_data;
              out_word.column       = 12'(col);
              out_word.row          = 12'(rw);
              out_word.image_width  = 13'(mid_width);
              out_word.image_height = 13'(mid_height);
              out_word.last_pixel   = last;
              byte_in_pixel_nxt     = 2'd0;
              if (!row_end) begin
                column_nxt = col + 1'b1;
              end else begin
                column_nxt = '0;
                if (last) begin
                  bph_nxt = BPH_IDLE;
                end else begin
                  row_nxt = rw + 1'b1;
                  // row padding in bytes equals width mod 4 for 3-byte pixels
                  pad_nxt = mid_width[1:0];
                  if (mid_width[1:0] != 2'd0) begin
                    bph_nxt = BPH_PAD;
                  end
                end
              end
            end
          end
          default: begin
            bph_nxt = BPH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bph_r           <= BPH_IDLE;
      column_r        <= '0;
      row_r           <= '0;
      byte_in_pixel_r <= '0;
      pad_r           <= '0;
    end else begin
      bph_r           <= bph_nxt;
      column_r        <= column_nxt;
      row_r           <= row_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      pad_r           <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_blue_r  <= held_blue_nxt;
    held_green_r <= held_green_nxt;
  end

  // a result is only produced from a command actually taken
  a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> mid_pop)
    else $error("result pushed without consuming a command");

  // the last pixel of an image leaves the assembler idle
  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && out_word.last_pixel) |=> (bph_r == BPH_IDLE))
    else $error("assembler not idle after last pixel");

  // byte position within a pixel stays in 0..2
  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_in_pixel_r != 2'd3)
    else $error("byte_in_pixel out of range");

  // padding phase always has bytes left to skip
  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (bph_r == BPH_PAD) |-> (pad_r != 2'd0))
    else $error("padding phase with zero pad count");

endmodule

// ----- rtl/bmp24_pixel_stream_parser.sv -----
`timescale 1ns / 1ps
// Path: byte -> command queue -> assembler -> result queue (empty low).
// Throughput: one byte per cycle unless full stalls it, set by the one-word-per-cycle
// command queue between parser and assembler and the result queue behind it.
// Reset: synchronous, active low; clears both queues and all parse state; the
// first byte after reset counts as offset 0 even without file_start.
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_parser: 24-bit BMP byte stream to pixel words
// Front end parses the 54-byte header (width, height, size check); a two-entry
// command queue feeds the back end, which assembles BGR pixels, tracks column
// and row, skips row padding and writes a two-entry result queue.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_parser
  import bpp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  // pixel word queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic        out_last_pixel,
  output logic        out_size_error
);

  // dimensions that pass the check fit in DIM_W bits; at least 2 for pad math
  localparam int DIM_RAW = $clog2(MAX_DIM + 1);
  localparam int DIM_W   = (DIM_RAW < 2) ? 2 : DIM_RAW;
  localparam int MID_W   = $bits(mid_ctl_t) + 8 + 2 * DIM_W;
  localparam int RES_W   = $bits(result_t);

  logic             mid_push, mid_full, mid_pop, mid_empty;
  mid_ctl_t         f_ctl, b_ctl;
  logic [7:0]       f_data, b_data;
  logic [DIM_W-1:0] f_width, f_height, b_width, b_height;
  logic [MID_W-1:0] mid_wr, mid_rd;

  logic             res_push, res_full;
  result_t          res_wr, res_rd;

  // The front takes a byte whenever the command queue has room, even for
  // header bytes that produce no command.
  assign full = mid_full;

  bpp_front #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .data_byte  (in_data_byte),
    .file_start (in_file_start),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_ctl    (f_ctl),
    .mid_data   (f_data),
    .mid_width  (f_width),
    .mid_height (f_height)
  );

  assign mid_wr = {f_ctl, f_data, f_width, f_height};
  assign {b_ctl, b_data, b_width, b_height} = mid_rd;

  bpp_fifo #(
    .W (MID_W)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  bpp_back #(
    .DIM_W (DIM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_pop    (mid_pop),
    .mid_ctl    (b_ctl),
    .mid_data   (b_data),
    .mid_width  (b_width),
    .mid_height (b_height),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_word   (res_wr)
  );

  // result queue decouples the assembler from the consumer's pop
  bpp_fifo #(
    .W (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_blue         = res_rd.blue;
  assign out_green        = res_rd.green;
  assign out_red          = res_rd.red;
  assign out_column       = res_rd.column;
  assign out_row          = res_rd.row;
  assign out_image_width  = res_rd.image_width;
  assign out_image_height = res_rd.image_height;
  assign out_last_pixel   = res_rd.last_pixel;
  assign out_size_error   = res_rd.size_error;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bmp24_pixel_stream_parser
// Streams BMP files (well-formed, truncated, bad-sized, noise) byte by byte
// into the push side. A model of the parser runs in step with each accepted
// byte and queues the pixel word it expects. A checker compares every popped
// word against the oldest queued one. Both sides stall in random bursts,
// except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb;
  import bpp_pkg::*;

  localparam int MAX_DIM     = 4096;
  localparam int RAND_BYTES  = 40;
  localparam int DRAIN_CYC   = 8;        // settle time after the last expected word
  localparam int CYCLE_LIMIT = 200000;   // hang guard limit on the run length

  // parse state of the model
  typedef enum logic [1:0] {
    PS_HEADER,
    PS_PIXELS,
    PS_PAD,
    PS_DONE
  } parse_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_file_start = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [12:0] out_image_width;
  logic [12:0] out_image_height;
  logic        out_last_pixel;
  logic        out_size_error;

  bmp24_pixel_stream_parser #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_file_start   (in_file_start),
    .empty           (empty),
    .pop             (pop),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_image_width (out_image_width),
    .out_image_height(out_image_height),
    .out_last_pixel  (out_last_pixel),
    .out_size_error  (out_size_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [5:0]   hdr_ofs;
  logic [31:0]  wid_acc;     // width shifts in LSB first from the top
  logic [31:0]  hgt_acc;
  parse_state_t pstate;
  logic [11:0]  col_cnt;
  logic [11:0]  row_cnt;
  logic [1:0]   byte_in_pix;
  logic [7:0]   held_blue;
  logic [7:0]   held_green;
  logic [1:0]   pad_left;

  result_t pending_words[$];   // expected pixel words, oldest first
  result_t got_word;
  result_t want_word;

  int  bytes_sent = 0;
  int  files_sent = 0;
  int  pix_checked = 0;
  int  err_checked = 0;
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  int  pop_stall = 0;
  bit  calm = 1'b0;            // no idling on either side when set

  function automatic void clear_parser_state();
    hdr_ofs     = '0;
    wid_acc     = '0;
    hgt_acc     = '0;
    pstate      = PS_HEADER;
    col_cnt     = '0;
    row_cnt     = '0;
    byte_in_pix = '0;
    held_blue   = '0;
    held_green  = '0;
    pad_left    = '0;
  endfunction

  // One accepted byte through the model; returns 1 when it yields a word.
  function automatic bit predict_parser_word(input logic [7:0] b, input logic fs,
                                             output result_t r);
    logic row_end;
    logic last_one;
    r = '0;
    if (fs) clear_parser_state();
    case (pstate)
      PS_HEADER: begin
        if (hdr_ofs >= DIM_OFFSET && hdr_ofs < DIM_OFFSET + 4)
          wid_acc = {b, wid_acc[31:8]};
        else if (hdr_ofs >= DIM_OFFSET + 4 && hdr_ofs < DIM_OFFSET + 8)
          hgt_acc = {b, hgt_acc[31:8]};
        // size check on the last height byte; negative heights land here too
        if (hdr_ofs == DIM_OFFSET + 7 &&
            (wid_acc == 32'd0 || wid_acc > 32'(MAX_DIM) ||
             hgt_acc == 32'd0 || hgt_acc > 32'(MAX_DIM))) begin
          pstate = PS_DONE;
          r.size_error = 1'b1;
          return 1'b1;
        end
        if (int'(hdr_ofs) + 1 >= PIXEL_OFFSET) begin
          pstate  = PS_PIXELS;
          hdr_ofs = '0;
        end else begin
          hdr_ofs = hdr_ofs + 6'd1;
        end
        return 1'b0;
      end
      PS_PAD: begin
        if (pad_left != 2'd0) pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) pstate = PS_PIXELS;
        return 1'b0;
      end
      PS_PIXELS: begin
        if (byte_in_pix == 2'd0) begin
          held_blue   = b;
          byte_in_pix = 2'd1;
          return 1'b0;
        end
        if (byte_in_pix == 2'd1) begin
          held_green  = b;
          byte_in_pix = 2'd2;
          return 1'b0;
        end
        row_end  = (32'(col_cnt) + 32'd1) >= wid_acc;
        last_one = row_end && ((32'(row_cnt) + 32'd1) >= hgt_acc);
        r.blue         = held_blue;
        r.green        = held_green;
        r.red          = b;
        r.column       = col_cnt;
        r.row          = row_cnt;
        r.image_width  = wid_acc[12:0];
        r.image_height = hgt_acc[12:0];
        r.last_pixel   = last_one;
        byte_in_pix = 2'd0;
        if (!row_end) begin
          col_cnt = col_cnt + 12'd1;
        end else begin
          col_cnt = '0;
          if (last_one) begin
            pstate = PS_DONE;
          end else begin
            row_cnt  = row_cnt + 12'd1;
            pad_left = wid_acc[1:0];   // row pad equals width mod 4 for 24 bpp
            if (pad_left != 2'd0) pstate = PS_PAD;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;   // done: ignore until next file_start
    endcase
  endfunction

  function automatic string word_text(input result_t w);
    return $sformatf("b=%02h g=%02h r=%02h col=%0d row=%0d w=%0d h=%0d last=%0b err=%0b",
                     w.blue, w.green, w.red, w.column, w.row, w.image_width,
                     w.image_height, w.last_pixel, w.size_error);
  endfunction

  // --------------------------------------------------------------------------
  // Byte sender: optional idle burst, then hold push until accepted.
  // push is left high after acceptance so back-to-back bytes never glitch it.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fs);
    result_t w;
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_data_byte  <= b;
    in_file_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_parser_word(b, fs, w)) begin
      pending_words.push_back(w);
    end
    bytes_sent++;
  endtask

  // One file: header with the given size fields, pixel rows with padding
  // (only if the size is legal), then trailing junk. cut > 0 truncates it.
  task automatic send_bmp(input logic [31:0] w_fld, input logic [31:0] h_fld,
                          input logic fs_first, input int cut, input int trail,
                          input bit pattern);
    int body;
    int total;
    int i;
    logic [7:0] b;
    if (w_fld != 0 && w_fld <= 32'(MAX_DIM) && h_fld != 0 && h_fld <= 32'(MAX_DIM))
      body = int'(h_fld) * (3 * int'(w_fld) + int'(w_fld[1:0]));
    else
      body = 0;
    total = PIXEL_OFFSET + body + trail;
    if (cut > 0 && cut < total) total = cut;
    for (i = 0; i < total; i++) begin
      b = pattern ? ((i & 1) ? 8'hff : 8'h00) : 8'($urandom);
      if (i >= DIM_OFFSET && i < DIM_OFFSET + 4)
        b = w_fld[8 * (i - DIM_OFFSET) +: 8];
      else if (i >= DIM_OFFSET + 4 && i < DIM_OFFSET + 8)
        b = h_fld[8 * (i - DIM_OFFSET - 4) +: 8];
      send_byte(b, (i == 0) ? fs_first : 1'b0);
    end
    files_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // first bytes after reset with no file_start: must still count as offset 0;
  // pixel bytes alternate 00/ff; width 1 gives a one-byte row pad
  task automatic test_stream_after_reset();
    send_bmp(32'd1, 32'd2, 1'b0, 0, 0, 1'b1);
  endtask

  // widths 2 and 3 give pads of 2 and 3; the quiet tail covers no pad
  task automatic test_row_padding();
    send_bmp(32'd2, 32'd2, 1'b1, 0, 0, 1'b0);
    send_bmp(32'd3, 32'd2, 1'b1, 0, 0, 1'b0);
  endtask

  // zero width, oversize height, negative height; the junk byte after is ignored
  task automatic test_size_errors();
    send_bmp(32'd0, 32'd3, 1'b1, DIM_OFFSET + 9, 0, 1'b0);
    send_bmp(32'd1, 32'(MAX_DIM + 1), 1'b1, DIM_OFFSET + 9, 0, 1'b0);
    send_bmp(32'd2, 32'hffff_fffe, 1'b1, DIM_OFFSET + 9, 0, 1'b0);
  endtask

  // file_start lands in the width field, mid pixel, and mid pad
  task automatic test_restart_mid_file();
    send_bmp(32'd3, 32'd2, 1'b1, DIM_OFFSET + 2, 0, 1'b0);
    send_bmp(32'd1, 32'd2, 1'b1, PIXEL_OFFSET + 2, 0, 1'b0);
    send_bmp(32'd2, 32'd2, 1'b1, PIXEL_OFFSET + 7, 0, 1'b0);
  endtask

  // small random files, bad sizes, truncations and noise
  task automatic test_random_files();
    int start_bytes;
    int kind;
    int w;
    int h;
    logic [31:0] wf;
    logic [31:0] hf;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RAND_BYTES) begin
      kind = $urandom_range(0, 9);
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 2);
      if (kind < 5) begin
        send_bmp(32'(w), 32'(h), 1'b1, 0, $urandom_range(0, 3), 1'b0);
      end else if (kind < 7) begin
        case ($urandom_range(0, 3))
          0:       begin wf = 32'd0; hf = 32'(h); end
          1:       begin wf = 32'(w); hf = 32'd0; end
          2:       begin wf = 32'(MAX_DIM + 1 + $urandom_range(0, 1000)); hf = 32'(h); end
          default: begin wf = $urandom; hf = $urandom | 32'h8000_0000; end
        endcase
        send_bmp(wf, hf, 1'b1, DIM_OFFSET + 9, 0, 1'b0);
      end else if (kind < 9) begin
        send_bmp(32'(w), 32'(h), 1'b1,
                 $urandom_range(1, PIXEL_OFFSET + h * (3 * w + (w & 3)) - 1), 0, 1'b0);
      end else begin
        // loose bytes, file_start now and then
        repeat ($urandom_range(1, 16)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // back-to-back traffic, no stalls anywhere; width 4 needs no row pad
  task automatic test_quiet_tail();
    calm = 1'b1;
    send_bmp(32'd4, 32'd2, 1'b1, 0, 2, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop stalls, then compare each popped word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      pop_stall <= $urandom_range(0, 11);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      got_word = {out_blue, out_green, out_red, out_column, out_row,
                  out_image_width, out_image_height, out_last_pixel, out_size_error};
      if (pending_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected word: %s", word_text(got_word));
      end else begin
        want_word = pending_words.pop_front();
        if (got_word !== want_word) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch expected: %s", word_text(want_word));
            $display("         actual:   %s", word_text(got_word));
          end
        end
        if (want_word.size_error) err_checked++;
        else pix_checked++;
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               pending_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clear_parser_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_stream_after_reset();
    test_row_padding();
    test_size_errors();
    test_restart_mid_file();
    test_random_files();
    test_quiet_tail();

    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);   // catch any stray extra word

    $display("%0d bytes in %0d files: %0d pixel words and %0d size errors checked",
             bytes_sent, files_sent, pix_checked, err_checked);
    $display("covered pads 0-3, bad sizes, restarts in header, pixel and pad, noise bytes");
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
